FILE: sv/lswc_pkg.sv
// Shared constants and types for the line segment window clipper.
package lswc_pkg;

  localparam int COORD_BITS = 16;
  // Request to result: front register, queue, multiply, divide stages, result register.
  localparam int LATENCY    = COORD_BITS + 4;
  localparam int CFG_BITS   = 2;

  localparam logic [CFG_BITS-1:0] REG_X_MIN = 2'd0;
  localparam logic [CFG_BITS-1:0] REG_Y_MIN = 2'd1;
  localparam logic [CFG_BITS-1:0] REG_X_MAX = 2'd2;
  localparam logic [CFG_BITS-1:0] REG_Y_MAX = 2'd3;

  localparam logic signed [COORD_BITS-1:0] RST_X_MIN = COORD_BITS'(0);
  localparam logic signed [COORD_BITS-1:0] RST_Y_MIN = COORD_BITS'(0);
  localparam logic signed [COORD_BITS-1:0] RST_X_MAX = COORD_BITS'(255);
  localparam logic signed [COORD_BITS-1:0] RST_Y_MAX = COORD_BITS'(255);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_min;
    logic signed [COORD_BITS-1:0] y_min;
    logic signed [COORD_BITS-1:0] x_max;
    logic signed [COORD_BITS-1:0] y_max;
  } window_t;

  // One edge crossing to evaluate: |dq| * |n| / |dp| applied to q0
  typedef struct packed {
    logic                         try_ok;
    logic                         neg;
    logic signed [COORD_BITS-1:0] q0;
    logic [COORD_BITS-1:0]        mag_dq;
    logic [COORD_BITS-1:0]        mag_n;
    logic [COORD_BITS-1:0]        mag_dp;
  } cross_req_t;

  typedef struct packed {
    logic                         try_ok;
    logic                         neg;
    logic signed [COORD_BITS-1:0] q0;
  } cross_side_t;

  // Classification of one endpoint
  typedef struct packed {
    logic                         outside;
    logic                         in_win;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] ev;
    logic signed [COORD_BITS-1:0] eh;
  } point_info_t;

  typedef struct packed {
    point_info_t pa;
    point_info_t pb;
  } point_pair_t;

  typedef struct packed {
    cross_req_t  av;
    cross_req_t  ah;
    cross_req_t  bv;
    cross_req_t  bh;
    point_pair_t pts;
  } seg_req_t;

endpackage

FILE: sv/lswc_front.sv
// Front end: takes a segment request, classifies endpoints, sets up crossings.
module lswc_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  take,
  input  logic signed [lswc_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [lswc_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [lswc_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [lswc_pkg::COORD_BITS-1:0] end_y,
  input  lswc_pkg::window_t                     win,
  output logic                                  req_valid,
  output lswc_pkg::seg_req_t                    req
);
  import lswc_pkg::*;

  localparam int CB = COORD_BITS;

  seg_req_t req_next;
  logic     va, ha, vb, hb;

  function automatic cross_req_t mk_cross(
    input logic signed [CB-1:0] p0, input logic signed [CB-1:0] p1,
    input logic signed [CB-1:0] q0, input logic signed [CB-1:0] q1,
    input logic signed [CB-1:0] e,  input logic region);
    logic signed [CB:0] dp, dq, n;
    logic [CB:0]        adp, adq, an;
    logic               in_range;
    cross_req_t         r;
    dp  = {p1[CB-1], p1} - {p0[CB-1], p0};
    dq  = {q1[CB-1], q1} - {q0[CB-1], q0};
    n   = {e[CB-1], e} - {p0[CB-1], p0};
    adp = dp[CB] ? -dp : dp;
    adq = dq[CB] ? -dq : dq;
    an  = n[CB] ? -n : n;
    in_range = (e >= p0 && e <= p1) || (e >= p1 && e <= p0);
    r.try_ok = region && (dp != '0) && in_range;
    r.neg    = (dq[CB] ^ n[CB]) ^ dp[CB];
    r.q0     = q0;
    r.mag_dq = adq[CB-1:0];
    r.mag_n  = an[CB-1:0];
    r.mag_dp = adp[CB-1:0];
    return r;
  endfunction

  function automatic point_info_t classify(
    input logic signed [CB-1:0] x, input logic signed [CB-1:0] y, input window_t w,
    output logic vreg, output logic hreg);
    logic        left, right, below, above;
    point_info_t p;
    left  = x < w.x_min;
    right = !left && (x > w.x_max);
    below = y < w.y_min;
    above = !below && (y > w.y_max);
    vreg  = left || right;
    hreg  = below || above;
    p.outside = vreg || hreg;
    p.in_win  = (x >= w.x_min) && (x <= w.x_max) && (y >= w.y_min) && (y <= w.y_max);
    p.px = x;
    p.py = y;
    p.ev = left ? w.x_min : w.x_max;
    p.eh = below ? w.y_min : w.y_max;
    return p;
  endfunction

  // Classification and crossing setup
  always_comb begin
    req_next.pts.pa = classify(start_x, start_y, win, va, ha);
    req_next.pts.pb = classify(end_x, end_y, win, vb, hb);
    req_next.av = mk_cross(start_x, end_x, start_y, end_y, req_next.pts.pa.ev, va);
    req_next.ah = mk_cross(start_y, end_y, start_x, end_x, req_next.pts.pa.eh, ha);
    req_next.bv = mk_cross(start_x, end_x, start_y, end_y, req_next.pts.pb.ev, vb);
    req_next.bh = mk_cross(start_y, end_y, start_x, end_x, req_next.pts.pb.eh, hb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req <= req_next;
    end
  end

endmodule

FILE: sv/lswc_queue.sv
// Two-entry request queue between front and back end.
module lswc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lswc_pkg::seg_req_t push_data,
  input  logic               pop,
  output logic               not_empty,
  output logic               full,
  output lswc_pkg::seg_req_t head
);
  import lswc_pkg::*;

  seg_req_t   entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: sv/lswc_cross.sv
// Crossing unit: registered multiply, then one restoring divide step per stage.
module lswc_cross (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  lswc_pkg::cross_req_t            req,
  output logic                            out_valid,
  output lswc_pkg::cross_side_t           out_side,
  output logic [lswc_pkg::COORD_BITS-1:0] out_m
);
  import lswc_pkg::*;

  localparam int CB = COORD_BITS;

  logic [2*CB-1:0] prod;
  logic            v     [CB+1];
  cross_side_t     side  [CB+1];
  logic [CB-1:0]   den   [CB+1];
  logic [CB-1:0]   rem   [CB+1];
  logic [CB-1:0]   low   [CB+1];
  logic [CB-1:0]   quo   [CB+1];

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= req.mag_dq * req.mag_n;
    den[0]  <= req.mag_dp;
    side[0] <= '{try_ok: req.try_ok, neg: req.neg, q0: req.q0};
  end

  assign rem[0] = prod[2*CB-1:CB];
  assign low[0] = prod[CB-1:0];
  assign quo[0] = '0;

  // Divide stages, one quotient bit each
  for (genvar s = 0; s < CB; s++) begin : g_div
    logic [CB:0] trial, diff;
    logic        ge;
    assign trial = {rem[s], low[s][CB-1]};
    assign diff  = trial - {1'b0, den[s]};
    assign ge    = trial >= {1'b0, den[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      rem[s+1]  <= ge ? diff[CB-1:0] : trial[CB-1:0];
      low[s+1]  <= {low[s][CB-2:0], 1'b0};
      quo[s+1]  <= {quo[s][CB-2:0], ge};
      den[s+1]  <= den[s];
      side[s+1] <= side[s];
    end
  end

  assign out_valid = v[CB];
  assign out_side  = side[CB];
  assign out_m     = quo[CB];

endmodule

FILE: sv/lswc_back.sv
// Back end: four crossing units, endpoint delay line and result selection.
module lswc_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  lswc_pkg::seg_req_t                     req,
  input  lswc_pkg::window_t                      win,
  output logic                                   done,
  output logic                                   accepted,
  output logic signed [lswc_pkg::COORD_BITS-1:0] clip_start_x,
  output logic signed [lswc_pkg::COORD_BITS-1:0] clip_start_y,
  output logic signed [lswc_pkg::COORD_BITS-1:0] clip_end_x,
  output logic signed [lswc_pkg::COORD_BITS-1:0] clip_end_y
);
  import lswc_pkg::*;

  localparam int CB = COORD_BITS;

  logic          av_v, ah_v, bv_v, bh_v;
  cross_side_t   av_s, ah_s, bv_s, bh_s;
  logic [CB-1:0] av_m, ah_m, bv_m, bh_m;
  point_pair_t   pts [CB+1];
  logic          a_ok, b_ok;
  logic signed [CB-1:0] ax, ay, bx, by;

  lswc_cross u_av (.clk, .rst, .in_valid, .req(req.av),
                   .out_valid(av_v), .out_side(av_s), .out_m(av_m));
  lswc_cross u_ah (.clk, .rst, .in_valid, .req(req.ah),
                   .out_valid(ah_v), .out_side(ah_s), .out_m(ah_m));
  lswc_cross u_bv (.clk, .rst, .in_valid, .req(req.bv),
                   .out_valid(bv_v), .out_side(bv_s), .out_m(bv_m));
  lswc_cross u_bh (.clk, .rst, .in_valid, .req(req.bh),
                   .out_valid(bh_v), .out_side(bh_s), .out_m(bh_m));

  // Endpoint info follows the crossing units
  always_ff @(posedge clk) begin
    pts[0] <= req.pts;
    for (int i = 0; i < CB; i++) begin
      pts[i+1] <= pts[i];
    end
  end

  function automatic logic signed [CB+1:0] sx(input logic signed [CB-1:0] a);
    return {{2{a[CB-1]}}, a};
  endfunction

  function automatic logic signed [CB+1:0] apply(input cross_side_t s,
                                                 input logic [CB-1:0] m);
    logic signed [CB+1:0] mm;
    mm = {2'b00, m};
    return s.neg ? sx(s.q0) - mm : sx(s.q0) + mm;
  endfunction

  // Pick the surviving point for one endpoint
  function automatic logic pick(
    input point_info_t p, input cross_side_t vs, input logic [CB-1:0] vm,
    input cross_side_t hs, input logic [CB-1:0] hm, input window_t w,
    output logic signed [CB-1:0] rx, output logic signed [CB-1:0] ry);
    logic signed [CB+1:0] qv, qh;
    logic                 v_ok, h_ok;
    qv = apply(vs, vm);
    qh = apply(hs, hm);
    v_ok = vs.try_ok && (p.ev >= w.x_min) && (p.ev <= w.x_max) &&
           (qv >= sx(w.y_min)) && (qv <= sx(w.y_max));
    h_ok = hs.try_ok && (p.eh >= w.y_min) && (p.eh <= w.y_max) &&
           (qh >= sx(w.x_min)) && (qh <= sx(w.x_max));
    rx = p.px;
    ry = p.py;
    if (!p.outside) begin
      return p.in_win;
    end else if (v_ok) begin
      rx = p.ev;
      ry = qv[CB-1:0];
      return 1'b1;
    end else if (h_ok) begin
      rx = qh[CB-1:0];
      ry = p.eh;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always_comb begin
    a_ok = pick(pts[CB].pa, av_s, av_m, ah_s, ah_m, win, ax, ay);
    b_ok = pick(pts[CB].pb, bv_s, bv_m, bh_s, bh_m, win, bx, by);
  end

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= av_v;
    end
  end

  always_ff @(posedge clk) begin
    accepted     <= a_ok && b_ok;
    clip_start_x <= (a_ok && b_ok) ? ax : '0;
    clip_start_y <= (a_ok && b_ok) ? ay : '0;
    clip_end_x   <= (a_ok && b_ok) ? bx : '0;
    clip_end_y   <= (a_ok && b_ok) ? by : '0;
  end

  // Units run in lockstep; their valid flags are equal
  logic unused_v;
  assign unused_v = ah_v ^ bv_v ^ bh_v;

endmodule

FILE: sv/line_segment_window_clipper.sv
// Top level of the line segment window clipper.
// From start to done a segment passes the front register, the queue, the multiply stage and
// the one-bit-per-stage divide pipeline in each crossing unit, and the result register.
// Throughput: one segment per cycle; busy stays low in normal operation.
// The receiver cannot stall: each result shows for one cycle with done.
// Synchronous reset clears the pipeline and loads the default window (0,0)-(255,255).
module line_segment_window_clipper (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [lswc_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [lswc_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [lswc_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [lswc_pkg::COORD_BITS-1:0] end_y,
  input  logic                                   cfg_write,
  input  logic [lswc_pkg::CFG_BITS-1:0]          cfg_index,
  input  logic [lswc_pkg::COORD_BITS-1:0]        cfg_data,
  output logic                                   done,
  output logic                                   accepted,
  output logic signed [lswc_pkg::COORD_BITS-1:0] clip_start_x,
  output logic signed [lswc_pkg::COORD_BITS-1:0] clip_start_y,
  output logic signed [lswc_pkg::COORD_BITS-1:0] clip_end_x,
  output logic signed [lswc_pkg::COORD_BITS-1:0] clip_end_y
);
  import lswc_pkg::*;

  window_t  win;
  logic     front_valid, q_not_empty, q_full;
  seg_req_t front_req, q_head;

  // Window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '{x_min: RST_X_MIN, y_min: RST_Y_MIN, x_max: RST_X_MAX, y_max: RST_Y_MAX};
    end else if (cfg_write) begin
      case (cfg_index)
        REG_X_MIN: win.x_min <= cfg_data;
        REG_Y_MIN: win.y_min <= cfg_data;
        REG_X_MAX: win.x_max <= cfg_data;
        REG_Y_MAX: win.y_max <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = q_full;

  lswc_front u_front (
    .clk, .rst, .take(start && !busy),
    .start_x, .start_y, .end_x, .end_y, .win,
    .req_valid(front_valid), .req(front_req)
  );

  lswc_queue u_queue (
    .clk, .rst, .push(front_valid), .push_data(front_req),
    .pop(q_not_empty), .not_empty(q_not_empty), .full(q_full), .head(q_head)
  );

  lswc_back u_back (
    .clk, .rst, .in_valid(q_not_empty), .req(q_head), .win,
    .done, .accepted, .clip_start_x, .clip_start_y, .clip_end_x, .clip_end_y
  );

endmodule

FILE: sv/lswc_checker.sv
// Port-level checks for the clipper, bound to the top level.
module lswc_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   start,
  input logic                                   busy,
  input logic                                   done,
  input logic                                   accepted,
  input logic signed [lswc_pkg::COORD_BITS-1:0] clip_start_x,
  input logic signed [lswc_pkg::COORD_BITS-1:0] clip_start_y,
  input logic signed [lswc_pkg::COORD_BITS-1:0] clip_end_x,
  input logic signed [lswc_pkg::COORD_BITS-1:0] clip_end_y
);
  import lswc_pkg::*;

  // Every request gets its result after the fixed latency
  a_req_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("request without result");

  // No result without a request
  a_result_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without request");

  // Rejected segments carry zero endpoints
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && !accepted |-> clip_start_x == '0 && clip_start_y == '0 &&
                          clip_end_x == '0 && clip_end_y == '0)
    else $error("rejected result not zeroed");

  // Reset flushes pending results
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result after reset");

endmodule

bind line_segment_window_clipper lswc_checker u_lswc_checker (.*);
